[src/trp_pkg.sv]
// shared types and codes of the telnet receive parser
`default_nettype none
package trp_pkg;

  localparam int unsigned SUBNEG_DEPTH_DEF = 64;

  localparam logic [7:0] CODE_NUL  = 8'h00;
  localparam logic [7:0] CODE_LF   = 8'h0a;
  localparam logic [7:0] CODE_CR   = 8'h0d;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_IAC  = 8'd255;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_CMD     = 3'd1,
    KIND_NEG     = 3'd2,
    KIND_REFUSE  = 3'd3,
    KIND_SUBNEG  = 3'd4,
    KIND_SBEMPTY = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] opt;
    logic       last;
  } res_t;

  typedef struct packed {
    logic r0_vld;
    res_t r0;
    logic r1_vld;
    res_t r1;
    logic two;
    logic drain;
  } dec_t;

endpackage
`default_nettype wire

[src/trp_ram.sv]
// generic single write, single read ram with registered read data
`default_nettype none
module trp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[src/trp_parser.sv]
// byte decoder with parse phase, pending cr, held command and store fill count
`default_nettype none
module trp_parser #(
  parameter int unsigned SUBNEG_DEPTH = trp_pkg::SUBNEG_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              acc_i,
  input  wire logic [7:0]                        byte_i,
  input  wire logic                              auto_refuse_i,
  output trp_pkg::dec_t                          dec_o,
  output logic                                   wr_en_o,
  output logic [$clog2(SUBNEG_DEPTH)-1:0]        wr_addr_o,
  output logic [7:0]                             wr_data_o,
  output logic [$clog2(SUBNEG_DEPTH+1)-1:0]      cnt_o,
  output logic [7:0]                             held_o
);

  localparam int unsigned AW = $clog2(SUBNEG_DEPTH);
  localparam int unsigned CW = $clog2(SUBNEG_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(SUBNEG_DEPTH);

  typedef enum logic [2:0] {
    PH_DATA, PH_IAC, PH_OPT, PH_SB, PH_SB2, PH_IAC2
  } phase_e;

  phase_e        phase_q, phase_d;
  logic          cr_q, cr_d;
  logic [7:0]    held_q, held_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          store;
  logic [7:0]    store_byte;
  trp_pkg::dec_t dec;

  always_comb begin
    phase_d    = phase_q;
    cr_d       = cr_q;
    held_d     = held_q;
    cnt_d      = cnt_q;
    store      = 1'b0;
    store_byte = byte_i;
    dec        = '0;
    dec.r0     = '{kind: trp_pkg::KIND_DATA, value: byte_i, opt: 8'h00, last: 1'b1};
    dec.r1     = '{kind: trp_pkg::KIND_DATA, value: byte_i, opt: 8'h00, last: 1'b1};
    unique case (phase_q)
      PH_IAC: begin
        if (byte_i == trp_pkg::CODE_IAC) begin
          phase_d    = PH_DATA;
          dec.r0_vld = 1'b1;
        end else if (byte_i == trp_pkg::CODE_SB) begin
          phase_d = PH_SB;
        end else if (byte_i >= trp_pkg::CODE_WILL && byte_i <= trp_pkg::CODE_DONT) begin
          phase_d = PH_OPT;
          held_d  = byte_i;
        end else begin
          phase_d       = PH_DATA;
          dec.r0_vld    = 1'b1;
          dec.r0.kind   = trp_pkg::KIND_CMD;
        end
      end
      PH_OPT: begin
        dec.r0.opt = byte_i;
        if (!auto_refuse_i) begin
          dec.r0_vld   = 1'b1;
          dec.r0.kind  = trp_pkg::KIND_NEG;
          dec.r0.value = held_q;
        end else if (held_q == trp_pkg::CODE_DO) begin
          dec.r0_vld   = 1'b1;
          dec.r0.kind  = trp_pkg::KIND_REFUSE;
          dec.r0.value = trp_pkg::CODE_WONT;
        end else if (held_q == trp_pkg::CODE_WILL) begin
          dec.r0_vld   = 1'b1;
          dec.r0.kind  = trp_pkg::KIND_REFUSE;
          dec.r0.value = trp_pkg::CODE_DONT;
        end
        held_d  = 8'h00;
        phase_d = PH_DATA;
      end
      PH_SB: begin
        held_d  = byte_i;
        cnt_d   = '0;
        phase_d = PH_SB2;
      end
      PH_SB2: begin
        if (byte_i == trp_pkg::CODE_IAC) begin
          phase_d = PH_IAC2;
        end else begin
          store = 1'b1;
        end
      end
      PH_IAC2: begin
        if (byte_i == trp_pkg::CODE_IAC) begin
          store   = 1'b1;
          phase_d = PH_SB2;
        end else if (byte_i == trp_pkg::CODE_SE) begin
          if (cnt_q == '0) begin
            dec.r0_vld = 1'b1;
            dec.r0     = '{kind: trp_pkg::KIND_SBEMPTY, value: 8'h00, opt: held_q,
                           last: 1'b1};
          end else begin
            dec.drain = 1'b1;
          end
          phase_d = PH_DATA;
        end
      end
      default: begin
        phase_d = PH_DATA;
        if (byte_i == trp_pkg::CODE_IAC) begin
          phase_d = PH_IAC;
        end else if (!cr_q) begin
          if (byte_i == trp_pkg::CODE_CR) begin
            cr_d = 1'b1;
          end else begin
            dec.r0_vld = 1'b1;
          end
        end else begin
          dec.r0_vld   = 1'b1;
          dec.r0.value = trp_pkg::CODE_CR;
          dec.r1_vld   = (byte_i != trp_pkg::CODE_NUL);
          dec.two      = dec.r1_vld;
          cr_d         = 1'b0;
        end
      end
    endcase
    dec.r0.last = !dec.r1_vld;
    if (store && cnt_q != FULL) begin
      cnt_d = cnt_q + CW'(1);
    end else begin
      store = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DATA;
      cr_q    <= 1'b0;
      held_q  <= 8'h00;
      cnt_q   <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      cr_q    <= cr_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
    end
  end

  assign dec_o     = dec;
  assign wr_en_o   = acc_i && store;
  assign wr_addr_o = cnt_q[AW-1:0];
  assign wr_data_o = store_byte;
  assign cnt_o     = cnt_q;
  assign held_o    = held_q;

endmodule
`default_nettype wire

[src/telnet_receive_parser.sv]
// telnet receive parser top level: output register, pending slot and store drain
//
//   channel      direction  handshake               payload
//   rx           in         rx_valid_i/rx_stall_o   rx_byte_i
//   res          out        res_valid_o/res_stall_i kind_o value_o option_code_o last_o
//   auto_refuse  in         auto_refuse_we_i        auto_refuse_i
//
// one byte a cycle while the output is not stalled and each byte gives at most one
// result; a cr pair giving two results parks the second in the pending slot, stalling rx
// iac se after n stored bytes drains the store at one byte a cycle from the ram
// read port while the output is not stalled, with no byte taken meanwhile
// reset clears control state only; the store needs no clearing pass
// a stalled output holds one result while one more waits in the pending slot
`default_nettype none
module telnet_receive_parser #(
  parameter int unsigned SUBNEG_DEPTH = trp_pkg::SUBNEG_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       auto_refuse_we_i,
  input  wire logic       auto_refuse_i,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      value_o,
  output logic [7:0]      option_code_o,
  output logic            last_o
);

  localparam int unsigned AW = $clog2(SUBNEG_DEPTH);
  localparam int unsigned CW = $clog2(SUBNEG_DEPTH + 1);

  typedef enum logic {S_IDLE, S_DRAIN} state_e;

  state_e          st_q, st_d;
  logic            auto_refuse_q;
  logic            out_vld_q, out_vld_d;
  trp_pkg::res_t   out_q, out_d;
  logic            pend_vld_q, pend_vld_d;
  trp_pkg::res_t   pend_q, pend_d;
  logic [CW-1:0]   rd_addr_q, rd_addr_d;
  logic [CW-1:0]   left_q, left_d;
  logic            rd_vld_q, rd_vld_d;

  trp_pkg::dec_t   dec;
  logic            acc;
  logic            out_free;
  logic            load_drain;
  logic            ren;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic [CW-1:0]   cnt;
  logic [7:0]      held;
  logic [7:0]      rdata;

  trp_parser #(
    .SUBNEG_DEPTH(SUBNEG_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .byte_i       (rx_byte_i),
    .auto_refuse_i(auto_refuse_q),
    .dec_o        (dec),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .cnt_o        (cnt),
    .held_o       (held)
  );

  trp_ram #(
    .WIDTH(8),
    .DEPTH(SUBNEG_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (ren),
    .raddr_i(rd_addr_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign out_free   = !out_vld_q || !res_stall_i;
  assign rx_stall_o = (st_q != S_IDLE) || pend_vld_q || (dec.two && !out_free);
  assign acc        = rx_valid_i && !rx_stall_o;
  assign load_drain = (st_q == S_DRAIN) && rd_vld_q && out_free;
  assign ren        = (st_q == S_DRAIN) && (rd_addr_q != cnt) && (!rd_vld_q || load_drain);

  always_comb begin
    st_d       = st_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    rd_addr_d  = rd_addr_q;
    left_d     = left_q;
    rd_vld_d   = rd_vld_q;
    if (out_vld_q && !res_stall_i) begin
      out_vld_d = 1'b0;
    end
    priority if (acc && dec.r0_vld) begin
      if (out_free) begin
        out_d     = dec.r0;
        out_vld_d = 1'b1;
        if (dec.r1_vld) begin
          pend_d     = dec.r1;
          pend_vld_d = 1'b1;
        end
      end else begin
        pend_d     = dec.r0;
        pend_vld_d = 1'b1;
      end
    end else if (pend_vld_q && out_free) begin
      out_d      = pend_q;
      out_vld_d  = 1'b1;
      pend_vld_d = 1'b0;
    end else if (load_drain) begin
      out_d     = '{kind: trp_pkg::KIND_SUBNEG, value: rdata, opt: held,
                    last: (left_q == CW'(1))};
      out_vld_d = 1'b1;
    end else begin
      out_d = out_q;
    end
    if (acc && dec.drain) begin
      st_d      = S_DRAIN;
      rd_addr_d = '0;
      left_d    = cnt;
      rd_vld_d  = 1'b0;
    end
    if (ren) begin
      rd_addr_d = rd_addr_q + CW'(1);
      rd_vld_d  = 1'b1;
    end else if (load_drain) begin
      rd_vld_d = 1'b0;
    end
    if (load_drain) begin
      left_d = left_q - CW'(1);
      if (left_q == CW'(1)) begin
        st_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= S_IDLE;
      auto_refuse_q <= 1'b0;
      out_vld_q     <= 1'b0;
      pend_vld_q    <= 1'b0;
      rd_addr_q     <= '0;
      left_q        <= '0;
      rd_vld_q      <= 1'b0;
    end else begin
      st_q       <= st_d;
      out_vld_q  <= out_vld_d;
      out_q      <= out_d;
      pend_vld_q <= pend_vld_d;
      pend_q     <= pend_d;
      rd_addr_q  <= rd_addr_d;
      left_q     <= left_d;
      rd_vld_q   <= rd_vld_d;
      if (auto_refuse_we_i) begin
        auto_refuse_q <= auto_refuse_i;
      end
    end
  end

  assign res_valid_o   = out_vld_q;
  assign kind_o        = out_q.kind;
  assign value_o       = out_q.value;
  assign option_code_o = out_q.opt;
  assign last_o        = out_q.last;

  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> out_vld_q)
    else $error("pending result without a held output beat");

  a_no_rx_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DRAIN) |-> !acc)
    else $error("rx beat taken during store drain");

  a_drain_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DRAIN) |-> (left_q != '0) && (rd_addr_q <= cnt))
    else $error("store drain counters out of range");

  a_drain_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_drain && left_q == CW'(1)) |=> (out_vld_q && out_q.last && st_q == S_IDLE))
    else $error("store drain did not end with a last beat");

endmodule
`default_nettype wire
